FILE: rtl/pcli_pkg.sv
package pcli_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_EXEC = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_UNSUP  = 3'd1;
   localparam logic [2:0] ST_TRUNC  = 3'd2;
   localparam logic [2:0] ST_RANGE  = 3'd3;
   localparam logic [2:0] ST_HALTED = 3'd4;

   localparam logic [1:0] AWAIT_NONE   = 2'd0;
   localparam logic [1:0] AWAIT_STRING = 2'd1;
   localparam logic [1:0] AWAIT_SERIAL = 2'd2;

   localparam logic [7:0] TYPE_WRITE32_LO = 8'h04;
   localparam logic [7:0] TYPE_WRITE32_HI = 8'h05;
   localparam logic [7:0] TYPE_STRING_LO  = 8'h06;
   localparam logic [7:0] TYPE_STRING_HI  = 8'h07;
   localparam logic [7:0] TYPE_SERIAL_LO  = 8'h08;
   localparam logic [7:0] TYPE_SERIAL_HI  = 8'h09;
   localparam logic [7:0] TYPE_IF_EQ_LO   = 8'h20;
   localparam logic [7:0] TYPE_IF_EQ_HI   = 8'h21;
   localparam logic [7:0] TYPE_ENDIF      = 8'hE2;

   localparam logic [3:0] WIDTH_CODE_WORD = 4'd2;
   localparam logic [3:0] WIDTH_CODE_HALF = 4'd1;

   localparam logic [15:0] SKIP_MAX = 16'hFFFF;

   localparam logic [1:0] REG_CODE_BASE  = 2'd0;
   localparam logic [1:0] REG_CODE_MASK  = 2'd1;
   localparam logic [1:0] REG_IMAGE_BASE = 2'd2;

   localparam logic [31:0] CODE_BASE_RESET  = 32'h8000_0000;
   localparam logic [31:0] CODE_MASK_RESET  = 32'h01FF_FFFF;
   localparam logic [31:0] IMAGE_BASE_RESET = 32'h8000_0000;

   typedef enum logic [2:0] {
      JOB_LOAD,
      JOB_READ,
      JOB_WORD,
      JOB_IF,
      JOB_STRING,
      JOB_SERIAL,
      JOB_ELEM
   } job_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ELEM,
      S_CHK,
      S_WR,
      S_RD,
      S_RDW,
      S_RDC,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [31:0] code_base;
      logic [31:0] code_mask;
      logic [31:0] image_base;
   } cfg_type;

   typedef struct packed {
      logic        capture;
      logic        setup;
      job_type     job;
      logic        write_byte;
      logic        read_byte;
      logic        elem_next;
      logic        upd_string;
      logic        clr_pmode;
      logic        endif_op;
      logic        deepen;
      logic        deepen_if_ne;
      logic        start_string;
      logic        start_serial;
      logic        set_status;
      logic [2:0]  status_val;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        halted;
      logic [1:0]  pmode;
      logic        skip_zero;
      logic [7:0]  line_kind;
      logic        rng_ok;
      logic        last_byte;
      logic        last_elem;
   } stat_type;

endpackage

FILE: rtl/pcli_datapath.sv
module pcli_datapath #(
   parameter int IMAGE_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  pcli_pkg::cfg_type  cfg,
   input  pcli_pkg::cmd_type  cmd,
   output pcli_pkg::stat_type stat,
   input  logic [1:0]        req_op,
   input  logic              req_list_start,
   input  logic              req_list_end,
   input  logic [31:0]       req_first_word,
   input  logic [31:0]       req_second_word,
   input  logic [9:0]        req_image_word_index,
   input  logic [31:0]       req_load_word,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_read_word,
   output logic [15:0]       rsp_skip_depth_now,
   output logic [1:0]        rsp_awaiting
);

   localparam int AW = $clog2(IMAGE_BYTES);

   logic [7:0] mem [IMAGE_BYTES];

   logic [1:0]  op_ff, op_in;
   logic        end_ff, end_in;
   logic [31:0] w1_ff, w1_in, w2_ff, w2_in, lw_ff, lw_in;
   logic [9:0]  widx_ff, widx_in;
   logic [15:0] skip_ff, skip_in;
   logic        halt_ff, halt_in;
   logic [1:0]  pmode_ff, pmode_in;
   logic [31:0] paddr_ff, paddr_in, left_ff, left_in, sval_ff, sval_in;
   logic [31:0] base_ff, base_in;
   logic [3:0]  nbytes_ff, nbytes_in;
   logic [2:0]  byte_ff, byte_in;
   logic [63:0] data_ff, data_in;
   logic [11:0] cnt_ff, cnt_in;
   logic [31:0] target_ff, target_in, value_ff, value_in, rdata_ff, rdata_in;
   logic        rd_pend_ff, rd_pend_in;
   logic [7:0]  mem_rd_ff;
   logic [2:0]  status_ff, status_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_read_ff, rsp_read_in;
   logic [15:0] rsp_skip_ff, rsp_skip_in;
   logic [1:0]  rsp_await_ff, rsp_await_in;

   logic [31:0] code_addr, off_code, off_if, off_pend, off_tgt, word_base, limit;
   logic [3:0]  strn, elemn;
   logic [31:0] sum_idx;
   logic [AW-1:0] mem_idx;
   logic        rng_ok, deepen_req, clear_err;
   logic [2:0]  fin_status;
   logic [15:0] endif_d;

   assign code_addr = cfg.code_base + (w1_ff & cfg.code_mask);
   assign off_code  = code_addr - cfg.image_base;
   assign off_if    = {code_addr[31:2], 2'b00} - cfg.image_base;
   assign off_pend  = paddr_ff - cfg.image_base;
   assign off_tgt   = target_ff - cfg.image_base;
   assign word_base = {20'd0, widx_ff, 2'b00};
   assign strn      = (left_ff < 32'd8) ? left_ff[3:0] : 4'd8;
   assign elemn     = (w1_ff[31:28] == pcli_pkg::WIDTH_CODE_WORD) ? 4'd4 :
                      (w1_ff[31:28] == pcli_pkg::WIDTH_CODE_HALF) ? 4'd2 : 4'd1;
   assign limit     = 32'(IMAGE_BYTES) - {28'd0, nbytes_ff};
   assign rng_ok    = base_ff <= limit;
   assign sum_idx   = base_ff + {29'd0, byte_ff};
   assign mem_idx   = sum_idx[AW-1:0];
   assign endif_d   = {8'd0, w1_ff[7:0]};
   assign deepen_req = cmd.deepen | (cmd.deepen_if_ne & (rdata_ff != w2_ff));
   assign fin_status = (status_ff == pcli_pkg::ST_OK && op_ff == pcli_pkg::OP_EXEC &&
                        end_ff && pmode_ff != pcli_pkg::AWAIT_NONE) ?
                       pcli_pkg::ST_TRUNC : status_ff;
   assign clear_err = cmd.finish && op_ff == pcli_pkg::OP_EXEC &&
                      fin_status != pcli_pkg::ST_OK;

   assign stat.op        = op_ff;
   assign stat.halted    = halt_ff;
   assign stat.pmode     = pmode_ff;
   assign stat.skip_zero = skip_ff == 16'd0;
   assign stat.line_kind = w1_ff[31:24];
   assign stat.rng_ok    = rng_ok;
   assign stat.last_byte = {1'b0, byte_ff} == (nbytes_ff - 4'd1);
   assign stat.last_elem = cnt_ff == w1_ff[27:16];

   always_comb begin
      op_in = op_ff;
      end_in = end_ff;
      w1_in = w1_ff;
      w2_in = w2_ff;
      lw_in = lw_ff;
      widx_in = widx_ff;
      skip_in = skip_ff;
      halt_in = halt_ff;
      pmode_in = pmode_ff;
      paddr_in = paddr_ff;
      left_in = left_ff;
      sval_in = sval_ff;
      base_in = base_ff;
      nbytes_in = nbytes_ff;
      byte_in = byte_ff;
      data_in = data_ff;
      cnt_in = cnt_ff;
      target_in = target_ff;
      value_in = value_ff;
      rdata_in = rdata_ff;
      status_in = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in = rsp_read_ff;
      rsp_skip_in = rsp_skip_ff;
      rsp_await_in = rsp_await_ff;
      rd_pend_in = cmd.read_byte;

      if (cmd.capture) begin
         op_in = req_op;
         end_in = req_list_end;
         w1_in = req_first_word;
         w2_in = req_second_word;
         lw_in = req_load_word;
         widx_in = req_image_word_index;
         status_in = pcli_pkg::ST_OK;
         if (req_op == pcli_pkg::OP_EXEC && req_list_start) begin
            skip_in = 16'd0;
            halt_in = 1'b0;
            pmode_in = pcli_pkg::AWAIT_NONE;
            paddr_in = 32'd0;
            left_in = 32'd0;
            sval_in = 32'd0;
         end
      end

      if (cmd.setup) begin
         byte_in = 3'd0;
         unique case (cmd.job)
            pcli_pkg::JOB_LOAD: begin
               base_in = word_base;
               nbytes_in = 4'd4;
               data_in = {lw_ff, 32'd0};
            end
            pcli_pkg::JOB_READ: begin
               base_in = word_base;
               nbytes_in = 4'd4;
            end
            pcli_pkg::JOB_WORD: begin
               base_in = off_code;
               nbytes_in = 4'd4;
               data_in = {w2_ff, 32'd0};
            end
            pcli_pkg::JOB_IF: begin
               base_in = off_if;
               nbytes_in = 4'd4;
            end
            pcli_pkg::JOB_STRING: begin
               base_in = off_pend;
               nbytes_in = strn;
               data_in = {w1_ff, w2_ff};
            end
            pcli_pkg::JOB_SERIAL: begin
               target_in = paddr_ff;
               value_in = sval_ff;
               cnt_in = 12'd0;
               pmode_in = pcli_pkg::AWAIT_NONE;
            end
            pcli_pkg::JOB_ELEM: begin
               base_in = off_tgt;
               nbytes_in = elemn;
               if (elemn == 4'd4) begin
                  data_in = {value_ff, 32'd0};
               end else if (elemn == 4'd2) begin
                  data_in = {value_ff[15:0], 48'd0};
               end else begin
                  data_in = {value_ff[7:0], 56'd0};
               end
            end
            default: begin
               base_in = base_ff;
            end
         endcase
      end

      if (cmd.write_byte) begin
         data_in = {data_ff[55:0], 8'd0};
         byte_in = byte_ff + 3'd1;
      end
      if (cmd.read_byte) begin
         byte_in = byte_ff + 3'd1;
      end
      if (rd_pend_ff) begin
         rdata_in = {rdata_ff[23:0], mem_rd_ff};
      end

      if (cmd.elem_next) begin
         target_in = target_ff + {16'd0, w1_ff[15:0]};
         value_in = value_ff + w2_ff;
         cnt_in = cnt_ff + 12'd1;
      end

      if (cmd.upd_string) begin
         paddr_in = paddr_ff + 32'd8;
         left_in = left_ff - {28'd0, strn};
         if (left_ff == {28'd0, strn}) begin
            pmode_in = pcli_pkg::AWAIT_NONE;
         end
      end
      if (cmd.clr_pmode) begin
         pmode_in = pcli_pkg::AWAIT_NONE;
      end

      if (cmd.endif_op) begin
         skip_in = (skip_ff > endif_d) ? skip_ff - endif_d : 16'd0;
      end
      if (deepen_req && skip_ff != pcli_pkg::SKIP_MAX) begin
         skip_in = skip_ff + 16'd1;
      end

      if (cmd.start_string && w2_ff != 32'd0) begin
         pmode_in = pcli_pkg::AWAIT_STRING;
         paddr_in = code_addr;
         left_in = w2_ff;
      end
      if (cmd.start_serial) begin
         pmode_in = pcli_pkg::AWAIT_SERIAL;
         paddr_in = code_addr;
         sval_in = w2_ff;
      end

      if (cmd.set_status) begin
         status_in = cmd.status_val;
      end

      if (cmd.finish) begin
         rsp_status_in = fin_status;
         rsp_read_in = (op_ff == pcli_pkg::OP_READ && status_ff == pcli_pkg::ST_OK) ?
                       rdata_ff : 32'd0;
         rsp_skip_in = skip_ff;
         rsp_await_in = clear_err ? pcli_pkg::AWAIT_NONE : pmode_ff;
         if (clear_err) begin
            halt_in = 1'b1;
            pmode_in = pcli_pkg::AWAIT_NONE;
            paddr_in = 32'd0;
            left_in = 32'd0;
            sval_in = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 16'd0;
         halt_ff <= 1'b0;
         pmode_ff <= pcli_pkg::AWAIT_NONE;
         paddr_ff <= 32'd0;
         left_ff <= 32'd0;
         sval_ff <= 32'd0;
         rd_pend_ff <= 1'b0;
      end else begin
         skip_ff <= skip_in;
         halt_ff <= halt_in;
         pmode_ff <= pmode_in;
         paddr_ff <= paddr_in;
         left_ff <= left_in;
         sval_ff <= sval_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      end_ff <= end_in;
      w1_ff <= w1_in;
      w2_ff <= w2_in;
      lw_ff <= lw_in;
      widx_ff <= widx_in;
      base_ff <= base_in;
      nbytes_ff <= nbytes_in;
      byte_ff <= byte_in;
      data_ff <= data_in;
      cnt_ff <= cnt_in;
      target_ff <= target_in;
      value_ff <= value_in;
      rdata_ff <= rdata_in;
      status_ff <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff <= rsp_read_in;
      rsp_skip_ff <= rsp_skip_in;
      rsp_await_ff <= rsp_await_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         mem[mem_idx] <= data_ff[63:56];
      end
      if (cmd.read_byte) begin
         mem_rd_ff <= mem[mem_idx];
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_read_word = rsp_read_ff;
   assign rsp_skip_depth_now = rsp_skip_ff;
   assign rsp_awaiting = rsp_await_ff;

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.write_byte |-> rng_ok) else $error("image write outside range");
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.read_byte |-> rng_ok) else $error("image read outside range");
   a_finish_no_read: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rd_pend_ff) else $error("beat finished with read in flight");

endmodule

FILE: rtl/pcli_ctrl.sv
module pcli_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  pcli_pkg::stat_type stat,
   output pcli_pkg::cmd_type  cmd
);

   pcli_pkg::state_type state_ff, state_in;
   pcli_pkg::job_type   job_ff, job_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcli_pkg::S_IDLE;
         job_ff <= pcli_pkg::JOB_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd = '0;
      cmd.job = job_ff;
      state_in = state_ff;
      job_in = job_ff;
      unique case (state_ff)
         pcli_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = pcli_pkg::S_DECODE;
            end
         end
         pcli_pkg::S_DECODE: begin
            state_in = pcli_pkg::S_FIN;
            priority if (stat.op == pcli_pkg::OP_LOAD) begin
               job_in = pcli_pkg::JOB_LOAD;
               state_in = pcli_pkg::S_CHK;
            end else if (stat.op == pcli_pkg::OP_READ) begin
               job_in = pcli_pkg::JOB_READ;
               state_in = pcli_pkg::S_CHK;
            end else if (stat.op != pcli_pkg::OP_EXEC) begin
               state_in = pcli_pkg::S_FIN;
            end else if (stat.halted) begin
               cmd.set_status = 1'b1;
               cmd.status_val = pcli_pkg::ST_HALTED;
            end else if (stat.pmode == pcli_pkg::AWAIT_STRING) begin
               if (stat.skip_zero) begin
                  job_in = pcli_pkg::JOB_STRING;
                  state_in = pcli_pkg::S_CHK;
               end else begin
                  cmd.upd_string = 1'b1;
               end
            end else if (stat.pmode == pcli_pkg::AWAIT_SERIAL) begin
               if (stat.skip_zero) begin
                  cmd.setup = 1'b1;
                  cmd.job = pcli_pkg::JOB_SERIAL;
                  job_in = pcli_pkg::JOB_ELEM;
                  state_in = pcli_pkg::S_ELEM;
               end else begin
                  cmd.clr_pmode = 1'b1;
               end
            end else begin
               unique case (stat.line_kind)
                  pcli_pkg::TYPE_ENDIF: cmd.endif_op = 1'b1;
                  pcli_pkg::TYPE_IF_EQ_LO, pcli_pkg::TYPE_IF_EQ_HI: begin
                     if (stat.skip_zero) begin
                        job_in = pcli_pkg::JOB_IF;
                        state_in = pcli_pkg::S_CHK;
                     end else begin
                        cmd.deepen = 1'b1;
                     end
                  end
                  pcli_pkg::TYPE_WRITE32_LO, pcli_pkg::TYPE_WRITE32_HI: begin
                     if (stat.skip_zero) begin
                        job_in = pcli_pkg::JOB_WORD;
                        state_in = pcli_pkg::S_CHK;
                     end
                  end
                  pcli_pkg::TYPE_STRING_LO, pcli_pkg::TYPE_STRING_HI: cmd.start_string = 1'b1;
                  pcli_pkg::TYPE_SERIAL_LO, pcli_pkg::TYPE_SERIAL_HI: cmd.start_serial = 1'b1;
                  default: begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = pcli_pkg::ST_UNSUP;
                  end
               endcase
            end
            if (state_in == pcli_pkg::S_CHK) begin
               cmd.setup = 1'b1;
               cmd.job = job_in;
            end
         end
         pcli_pkg::S_ELEM: begin
            cmd.setup = 1'b1;
            cmd.job = pcli_pkg::JOB_ELEM;
            state_in = pcli_pkg::S_CHK;
         end
         pcli_pkg::S_CHK: begin
            priority if (!stat.rng_ok) begin
               cmd.set_status = 1'b1;
               cmd.status_val = pcli_pkg::ST_RANGE;
               state_in = pcli_pkg::S_FIN;
            end else if (job_ff == pcli_pkg::JOB_READ || job_ff == pcli_pkg::JOB_IF) begin
               state_in = pcli_pkg::S_RD;
            end else begin
               state_in = pcli_pkg::S_WR;
            end
         end
         pcli_pkg::S_WR: begin
            cmd.write_byte = 1'b1;
            if (stat.last_byte) begin
               state_in = pcli_pkg::S_FIN;
               if (job_ff == pcli_pkg::JOB_STRING) begin
                  cmd.upd_string = 1'b1;
               end else if (job_ff == pcli_pkg::JOB_ELEM && !stat.last_elem) begin
                  cmd.elem_next = 1'b1;
                  state_in = pcli_pkg::S_ELEM;
               end
            end
         end
         pcli_pkg::S_RD: begin
            cmd.read_byte = 1'b1;
            if (stat.last_byte) begin
               state_in = pcli_pkg::S_RDW;
            end
         end
         pcli_pkg::S_RDW: state_in = pcli_pkg::S_RDC;
         pcli_pkg::S_RDC: begin
            cmd.deepen_if_ne = job_ff == pcli_pkg::JOB_IF;
            state_in = pcli_pkg::S_FIN;
         end
         pcli_pkg::S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in = pcli_pkg::S_IDLE;
            end
         end
         default: state_in = pcli_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_stall = state_ff != pcli_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_capture_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcli_pkg::S_IDLE && req_valid) |=> state_ff == pcli_pkg::S_DECODE)
      else $error("accepted beat not decoded");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == pcli_pkg::S_FIN)
      else $error("result raised outside finish");
   a_rd_job: assert property (@(posedge clock) disable iff (reset)
      state_ff == pcli_pkg::S_RD |-> (job_ff == pcli_pkg::JOB_READ || job_ff == pcli_pkg::JOB_IF))
      else $error("read sequence for write job");

endmodule

FILE: rtl/patch_code_list_interpreter.sv
// Sequence: an accepted beat is captured, then decoded; a line that touches image bytes is
// range checked, then writes its bytes one by one to the byte-wide image, or reads a word byte
// by byte and waits for the last byte; a serial fill repeats this per element. The result is then registered.
// Throughput: one beat at a time, as requests stall while the controller is busy; the next
// beat is taken the cycle after the result is loaded, and a stalled result holds the block.
// Reset clears control state and loads the configuration reset values; the image holds nothing until loaded.
module patch_code_list_interpreter #(
   parameter int IMAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic        req_list_start,
   input  logic        req_list_end,
   input  logic [31:0] req_first_word,
   input  logic [31:0] req_second_word,
   input  logic [9:0]  req_image_word_index,
   input  logic [31:0] req_load_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_read_word,
   output logic [15:0] rsp_skip_depth_now,
   output logic [1:0]  rsp_awaiting,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pcli_pkg::cfg_type  cfg_ff;
   pcli_pkg::cmd_type  cmd;
   pcli_pkg::stat_type stat;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_base <= pcli_pkg::CODE_BASE_RESET;
         cfg_ff.code_mask <= pcli_pkg::CODE_MASK_RESET;
         cfg_ff.image_base <= pcli_pkg::IMAGE_BASE_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[3:2] == pcli_pkg::REG_CODE_BASE) begin
            cfg_ff.code_base <= csr_pwdata;
         end
         if (csr_paddr[3:2] == pcli_pkg::REG_CODE_MASK) begin
            cfg_ff.code_mask <= csr_pwdata;
         end
         if (csr_paddr[3:2] == pcli_pkg::REG_IMAGE_BASE) begin
            cfg_ff.image_base <= csr_pwdata;
         end
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         pcli_pkg::REG_CODE_BASE:  csr_prdata = cfg_ff.code_base;
         pcli_pkg::REG_CODE_MASK:  csr_prdata = cfg_ff.code_mask;
         pcli_pkg::REG_IMAGE_BASE: csr_prdata = cfg_ff.image_base;
         default:                  csr_prdata = 32'd0;
      endcase
   end

   pcli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcli_datapath #(
      .IMAGE_BYTES (IMAGE_BYTES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_op               (req_op),
      .req_list_start       (req_list_start),
      .req_list_end         (req_list_end),
      .req_first_word       (req_first_word),
      .req_second_word      (req_second_word),
      .req_image_word_index (req_image_word_index),
      .req_load_word        (req_load_word),
      .rsp_status           (rsp_status),
      .rsp_read_word        (rsp_read_word),
      .rsp_skip_depth_now   (rsp_skip_depth_now),
      .rsp_awaiting         (rsp_awaiting)
   );

endmodule
